FILE: rtl/core/md5_pkg.sv
package md5_pkg;

    localparam logic [31:0] MD5_IV0 = 32'h67452301;
    localparam logic [31:0] MD5_IV1 = 32'hEFCDAB89;
    localparam logic [31:0] MD5_IV2 = 32'h98BADCFE;
    localparam logic [31:0] MD5_IV3 = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [2:0]  FULL_WORD = 3'd4;

    typedef struct packed {
        logic        is_end;
        logic [2:0]  nbytes;
        logic [31:0] data;
    } md5_entry_t;

    function automatic logic [31:0] md5_sine(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_shift(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_index(input logic [5:0] idx);
        logic [3:0] i;
        logic [3:0] g;
        i = idx[3:0];
        case (idx[5:4])
            2'd0: g = i;
            2'd1: g = i * 4'd5 + 4'd1;
            2'd2: g = i * 4'd3 + 4'd5;
            default: g = i * 4'd7;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_func(input logic [1:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rnd)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

FILE: rtl/core/md5_front.sv
module md5_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         data_byte,
    input  logic               has_byte,
    input  logic               end_of_message,
    output logic               push,
    output md5_pkg::md5_entry_t push_entry,
    input  logic               q_full
);
    import md5_pkg::*;

    logic [1:0]  lane_reg;
    logic [1:0]  lane_next;
    logic [31:0] word_reg;
    logic [31:0] merged;
    logic [31:0] padded;
    logic [2:0]  nb;
    logic        accept;

    assign byte_stall = q_full;
    assign accept = byte_valid & ~q_full;
    assign nb = {1'b0, lane_reg} + {2'b00, has_byte};

    always_comb
    begin
        merged = word_reg;
        if (has_byte)
        begin
            merged[{lane_reg, 3'b000} +: 8] = data_byte;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (3'(k) < nb)
            begin
                padded[k*8 +: 8] = merged[k*8 +: 8];
            end
            else if (3'(k) == nb)
            begin
                padded[k*8 +: 8] = PAD_BYTE;
            end
            else
            begin
                padded[k*8 +: 8] = 8'h00;
            end
        end
    end

    assign push = accept & (end_of_message | (has_byte & (lane_reg == 2'd3)));
    assign push_entry.is_end = end_of_message;
    assign push_entry.nbytes = nb;
    assign push_entry.data = end_of_message ? padded : merged;

    always_comb
    begin
        lane_next = lane_reg;
        if (accept)
        begin
            if (end_of_message)
            begin
                lane_next = 2'd0;
            end
            else if (has_byte)
            begin
                lane_next = lane_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= 2'd0;
        end
        else
        begin
            lane_reg <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_byte)
        begin
            word_reg <= merged;
        end
    end

endmodule

FILE: rtl/core/md5_queue.sv
module md5_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  md5_pkg::md5_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output md5_pkg::md5_entry_t pop_entry,
    output logic               not_empty
);
    import md5_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    md5_entry_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push = push & ~full;
    assign do_pop = pop & not_empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/md5_back.sv
module md5_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  md5_pkg::md5_entry_t q_entry,
    output logic               q_pop,
    output logic               digest_valid,
    input  logic               digest_stall,
    output logic [31:0]        digest_word,
    output logic [1:0]         word_index,
    output logic               last_word
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PADW,
        B_ZERO,
        B_LEN0,
        B_LEN1,
        B_ROUND,
        B_FOLD,
        B_OUT
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    state_t      after_reg;
    state_t      after_next;
    state_t      desired;
    logic [3:0]  wpos_reg;
    logic [3:0]  wpos_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [63:0] count_reg;
    logic [63:0] count_next;
    logic [1:0]  oidx_reg;
    logic [1:0]  oidx_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] block_reg [16];
    logic        wr_en;
    logic [31:0] wr_data;
    logic [63:0] bits;
    logic [31:0] round_sum;
    logic [31:0] round_t;

    assign bits = {count_reg[60:0], 3'b000};
    assign q_pop = (state_reg == B_IDLE) & q_valid;

    assign round_sum = a_reg + md5_func(cnt_reg[5:4], b_reg, c_reg, d_reg)
                     + md5_sine(cnt_reg) + block_reg[md5_index(cnt_reg)];
    assign round_t = b_reg + md5_rotl(round_sum, md5_shift(cnt_reg));

    assign digest_valid = (state_reg == B_OUT);
    assign digest_word = chain_reg[oidx_reg];
    assign word_index = oidx_reg;
    assign last_word = (oidx_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        desired = state_reg;
        wpos_next = wpos_reg;
        cnt_next = cnt_reg;
        count_next = count_reg;
        oidx_next = oidx_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        chain_next = chain_reg;
        wr_en = 1'b0;
        wr_data = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    wr_en = 1'b1;
                    wr_data = q_entry.data;
                    if (q_entry.is_end)
                    begin
                        count_next = count_reg + {61'd0, q_entry.nbytes};
                        desired = (q_entry.nbytes == FULL_WORD) ? B_PADW : B_ZERO;
                    end
                    else
                    begin
                        count_next = count_reg + 64'd4;
                        desired = B_IDLE;
                    end
                end
            end
            B_PADW:
            begin
                wr_en = 1'b1;
                wr_data = {24'd0, PAD_BYTE};
                desired = B_ZERO;
            end
            B_ZERO:
            begin
                if (wpos_reg == 4'd14)
                begin
                    state_next = B_LEN0;
                end
                else
                begin
                    wr_en = 1'b1;
                    desired = B_ZERO;
                end
            end
            B_LEN0:
            begin
                wr_en = 1'b1;
                wr_data = bits[31:0];
                desired = B_LEN1;
            end
            B_LEN1:
            begin
                wr_en = 1'b1;
                wr_data = bits[63:32];
                desired = B_OUT;
            end
            B_ROUND:
            begin
                a_next = d_reg;
                d_next = c_reg;
                c_next = b_reg;
                b_next = round_t;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = B_FOLD;
                end
            end
            B_FOLD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                state_next = after_reg;
            end
            B_OUT:
            begin
                if (!digest_stall)
                begin
                    if (oidx_reg == 2'd3)
                    begin
                        oidx_next = 2'd0;
                        count_next = '0;
                        chain_next[0] = MD5_IV0;
                        chain_next[1] = MD5_IV1;
                        chain_next[2] = MD5_IV2;
                        chain_next[3] = MD5_IV3;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (wr_en)
        begin
            wpos_next = wpos_reg + 4'd1;
            if (wpos_reg == 4'd15)
            begin
                state_next = B_ROUND;
                after_next = desired;
                cnt_next = '0;
                a_next = chain_reg[0];
                b_next = chain_reg[1];
                c_next = chain_reg[2];
                d_next = chain_reg[3];
            end
            else
            begin
                state_next = desired;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            after_reg <= B_IDLE;
            wpos_reg <= '0;
            cnt_reg <= '0;
            count_reg <= '0;
            oidx_reg <= '0;
            chain_reg[0] <= MD5_IV0;
            chain_reg[1] <= MD5_IV1;
            chain_reg[2] <= MD5_IV2;
            chain_reg[3] <= MD5_IV3;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            wpos_reg <= wpos_next;
            cnt_reg <= cnt_next;
            count_reg <= count_next;
            oidx_reg <= oidx_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        if (wr_en)
        begin
            block_reg[wpos_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/md5_stream_hasher.sv
// Per 64-byte block the back makes 16 word writes, 64 rounds and one fold; the queue
// holds the bytes off during the rounds, and twelve words then trickle in after them.
// After the end beat, the wait for the first digest word depends on how much zero
// fill is needed and whether a second padding block is needed.
// Asynchronous active-low reset restores the initial chain values; block words are not cleared.
module md5_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import md5_pkg::*;

    logic       push;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    md5_entry_t push_entry;
    md5_entry_t q_entry;

    md5_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .push           (push),
        .push_entry     (push_entry),
        .q_full         (q_full)
    );

    md5_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .not_empty  (q_valid)
    );

    md5_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

endmodule

FILE: rtl/core/md5_checker.sv
module md5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        digest_valid,
    input logic        digest_stall,
    input logic [31:0] digest_word,
    input logic [1:0]  word_index,
    input logic        last_word
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest_word)
            && $stable(word_index))
        else $error("digest beat changed while stalled");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !last_word |=> digest_valid
            && (word_index == $past(word_index) + 2'd1))
        else $error("digest words not delivered in order");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (word_index == 2'd0))
        else $error("digest does not start with the first word");

endmodule

bind md5_stream_hasher md5_checker u_md5_checker (.*);
